[rtl/tac_pkg.sv]
`timescale 1ns / 1ps
package tac_pkg;

	// Coordinate format of the input words
	localparam int COORD_W = 16;
	// Edge vector, product, cross product and triple product widths
	localparam int EW  = COORD_W + 1;
	localparam int PW  = 2 * EW;
	localparam int DW  = PW + 1;
	localparam int TPW = DW + EW;
	localparam int TW  = TPW + 2;
	// Register widths
	localparam int CTOL_W = 53;
	localparam int DTOL_W = 35;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = CTOL_W;
	// Ratio format: fraction bits and quotient bits
	localparam int QF = 16;
	localparam int QB = 32;
	localparam int FIFO_DEPTH = 4;

	localparam logic [CFG_INDEX_W-1:0] REG_COPLANAR_TOL    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DETERMINANT_TOL = 2'd1;

	typedef enum logic [2:0] {
		STATUS_XZ           = 3'd0,
		STATUS_XY           = 3'd1,
		STATUS_YZ           = 3'd2,
		STATUS_NOT_COPLANAR = 3'd3,
		STATUS_DEGENERATE   = 3'd4
	} status_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] base_x;
		logic signed [COORD_W-1:0] base_y;
		logic signed [COORD_W-1:0] base_z;
		logic signed [COORD_W-1:0] first_x;
		logic signed [COORD_W-1:0] first_y;
		logic signed [COORD_W-1:0] first_z;
		logic signed [COORD_W-1:0] second_x;
		logic signed [COORD_W-1:0] second_y;
		logic signed [COORD_W-1:0] second_z;
		logic signed [COORD_W-1:0] query_x;
		logic signed [COORD_W-1:0] query_y;
		logic signed [COORD_W-1:0] query_z;
	} tac_in_t;

	typedef struct packed {
		logic signed [31:0] alpha;
		logic signed [31:0] beta;
		status_t            status;
	} tac_out_t;

	// Classified word handed from front to back
	typedef struct packed {
		status_t               status;
		logic signed [DW-1:0]  det;
		logic signed [DW-1:0]  anum;
		logic signed [DW-1:0]  bnum;
	} tac_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

	// Projection axes in trial order: XZ, XY, YZ
	function automatic int axis_u(input int p);
		case (p)
			0: return 0;
			1: return 0;
			default: return 1;
		endcase
	endfunction

	function automatic int axis_v(input int p);
		case (p)
			0: return 2;
			1: return 1;
			default: return 2;
		endcase
	endfunction

endpackage

[rtl/tac_stream_if.sv]
`timescale 1ns / 1ps
interface tac_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[rtl/tac_front.sv]
`timescale 1ns / 1ps
module tac_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  tac_pkg::tac_in_t              item,
	input  logic [tac_pkg::CTOL_W-1:0]    ctol,
	input  logic [tac_pkg::DTOL_W-1:0]    dtol,
	output logic                          push_valid,
	input  logic                          push_ready,
	output tac_pkg::tac_job_t             job
);
	import tac_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [COORD_W-1:0] pts [4][3];
	logic signed [EW-1:0] e_d [3][3];
	logic signed [EW-1:0] e_s1 [3][3];

	logic signed [PW-1:0] dpa_s2 [3], dpb_s2 [3];
	logic signed [PW-1:0] apa_s2 [3], apb_s2 [3];
	logic signed [PW-1:0] bpa_s2 [3], bpb_s2 [3];
	logic signed [EW-1:0] e2_s2 [3];

	logic signed [DW-1:0] det_s3 [3], an_s3 [3], bn_s3 [3];
	logic signed [EW-1:0] e2_s3 [3];

	logic [DW-1:0] dmag [3];
	logic [2:0]    pass;
	status_t       sel_d;
	logic signed [DW-1:0] det_d, an_d, bn_d;

	logic signed [TPW-1:0] tp_s4 [3];
	status_t               sel_s4;
	logic signed [DW-1:0]  det_s4, an_s4, bn_s4;

	logic signed [TW-1:0]  t_s5;
	status_t               sel_s5;
	logic signed [DW-1:0]  det_s5, an_s5, bn_s5;

	logic [TW-1:0] tmag;

	// Whole front advances unless its last word is blocked by the queue
	assign en = !v_s5 || push_ready;
	assign in_ready = en;
	assign push_valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Edge vectors relative to the base vertex
	always_comb begin
		pts[0] = '{item.base_x, item.base_y, item.base_z};
		pts[1] = '{item.first_x, item.first_y, item.first_z};
		pts[2] = '{item.second_x, item.second_y, item.second_z};
		pts[3] = '{item.query_x, item.query_y, item.query_z};
		for (int k = 0; k < 3; k++) begin
			for (int p = 0; p < 3; p++) begin
				e_d[k][p] = EW'(pts[k+1][p]) - EW'(pts[0][p]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) e_s1 <= e_d;
	end

	// Products for each projection: determinant and both numerators
	for (genvar p = 0; p < 3; p++) begin : g_proj
		localparam int U = axis_u(p);
		localparam int V = axis_v(p);

		always_ff @(posedge clk) begin
			if (en) begin
				dpa_s2[p] <= PW'(e_s1[0][U]) * PW'(e_s1[1][V]);
				dpb_s2[p] <= PW'(e_s1[1][U]) * PW'(e_s1[0][V]);
				apa_s2[p] <= PW'(e_s1[1][V]) * PW'(e_s1[2][U]);
				apb_s2[p] <= PW'(e_s1[1][U]) * PW'(e_s1[2][V]);
				bpa_s2[p] <= PW'(e_s1[0][U]) * PW'(e_s1[2][V]);
				bpb_s2[p] <= PW'(e_s1[0][V]) * PW'(e_s1[2][U]);
				e2_s2[p]  <= e_s1[2][p];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				det_s3[p] <= DW'(dpa_s2[p]) - DW'(dpb_s2[p]);
				an_s3[p]  <= DW'(apa_s2[p]) - DW'(apb_s2[p]);
				bn_s3[p]  <= DW'(bpa_s2[p]) - DW'(bpb_s2[p]);
				e2_s3[p]  <= e2_s2[p];
			end
		end

		assign dmag[p] = det_s3[p][DW-1] ? DW'(-det_s3[p]) : DW'(det_s3[p]);
		assign pass[p] = dmag[p] > DW'(dtol);
	end

	// Pick the first projection whose determinant clears the tolerance
	always_comb begin
		sel_d = STATUS_DEGENERATE;
		det_d = det_s3[0];
		an_d  = an_s3[0];
		bn_d  = bn_s3[0];
		if (pass[0]) begin
			sel_d = STATUS_XZ;
		end else if (pass[1]) begin
			sel_d = STATUS_XY;
			det_d = det_s3[1];
			an_d  = an_s3[1];
			bn_d  = bn_s3[1];
		end else if (pass[2]) begin
			sel_d = STATUS_YZ;
			det_d = det_s3[2];
			an_d  = an_s3[2];
			bn_d  = bn_s3[2];
		end
	end

	// Triple product terms: normal = (detYZ, -detXZ, detXY)
	always_ff @(posedge clk) begin
		if (en) begin
			tp_s4[0] <= TPW'(det_s3[2]) * TPW'(e2_s3[0]);
			tp_s4[1] <= TPW'(det_s3[0]) * TPW'(e2_s3[1]);
			tp_s4[2] <= TPW'(det_s3[1]) * TPW'(e2_s3[2]);
			sel_s4   <= sel_d;
			det_s4   <= det_d;
			an_s4    <= an_d;
			bn_s4    <= bn_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s5   <= TW'(tp_s4[0]) - TW'(tp_s4[1]) + TW'(tp_s4[2]);
			sel_s5 <= sel_s4;
			det_s5 <= det_s4;
			an_s5  <= an_s4;
			bn_s5  <= bn_s4;
		end
	end

	// Coplanarity test decides the final class
	assign tmag = t_s5[TW-1] ? TW'(-t_s5) : TW'(t_s5);

	always_comb begin
		job.status = (tmag < TW'(ctol)) ? sel_s5 : STATUS_NOT_COPLANAR;
		job.det    = det_s5;
		job.anum   = an_s5;
		job.bnum   = bn_s5;
	end

endmodule

[rtl/tac_fifo.sv]
`timescale 1ns / 1ps
module tac_fifo #(
	parameter int DEPTH = tac_pkg::FIFO_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push_valid,
	output logic                   push_ready,
	input  tac_pkg::tac_job_t      push_data,
	output logic                   pop_valid,
	input  logic                   pop_ready,
	output tac_pkg::tac_job_t      pop_data,
	output tac_pkg::fifo_status_t  stat
);
	import tac_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tac_job_t      mem [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign stat.full  = count_q == CW'(DEPTH);
	assign stat.empty = count_q == '0;
	assign push_ready = !stat.full;
	assign pop_valid  = !stat.empty;
	assign pop_data   = mem[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Store incoming word
	always_ff @(posedge clk) begin
		if (do_push) mem[wr_ptr_q] <= push_data;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

[rtl/tac_back.sv]
`timescale 1ns / 1ps
module tac_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	output logic                 job_ready,
	input  tac_pkg::tac_job_t    job,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tac_pkg::tac_out_t    out_word
);
	import tac_pkg::*;

	typedef struct packed {
		logic [DW-1:0] rem;
		logic [QB-1:0] low;
		logic [QB-1:0] quo;
	} lane_t;

	typedef struct packed {
		status_t       status;
		logic [DW-1:0] d;
		lane_t         a;
		lane_t         b;
		logic          a_neg;
		logic          b_neg;
		logic          a_sat;
		logic          b_sat;
	} stage_t;

	logic          en;
	logic          v_s [QB+1];
	stage_t        st_s [QB+1];
	stage_t        prep;
	logic [DW-1:0] dm, am, bm;
	logic          out_v_q;
	tac_out_t      out_q;

	// One restoring step: bring in the next dividend bit, subtract if it fits
	function automatic lane_t div_step(input lane_t l, input logic [DW-1:0] d);
		logic [DW:0] t;
		logic [DW:0] diff;
		logic        ge;
		lane_t       r;
		t    = {l.rem, l.low[QB-1]};
		diff = t - {1'b0, d};
		ge   = t >= {1'b0, d};
		r.rem = ge ? diff[DW-1:0] : t[DW-1:0];
		r.low = {l.low[QB-2:0], 1'b0};
		r.quo = {l.quo[QB-2:0], ge};
		return r;
	endfunction

	// Apply sign and clamp to the signed 32-bit range
	function automatic logic [31:0] finish(input logic [QB-1:0] quo, input logic sat,
			input logic neg);
		logic [QB:0] mag;
		logic [QB:0] nmag;
		mag  = sat ? {1'b1, {QB{1'b0}}} : {1'b0, quo};
		nmag = (QB+1)'(0) - mag;
		if (neg) begin
			return (mag > (QB+1)'(33'h0_8000_0000)) ? 32'h8000_0000 : nmag[31:0];
		end
		return (mag > (QB+1)'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : mag[31:0];
	endfunction

	assign en        = !out_v_q || out_ready;
	assign job_ready = en;
	assign out_valid = out_v_q;
	assign out_word  = out_q;

	// Magnitudes, signs and the overflow check ahead of the divider
	always_comb begin
		dm = job.det[DW-1] ? DW'(-job.det) : DW'(job.det);
		am = job.anum[DW-1] ? DW'(-job.anum) : DW'(job.anum);
		bm = job.bnum[DW-1] ? DW'(-job.bnum) : DW'(job.bnum);
		prep.status = job.status;
		prep.d      = dm;
		prep.a_neg  = job.anum[DW-1] != job.det[DW-1];
		prep.b_neg  = job.bnum[DW-1] != job.det[DW-1];
		prep.a_sat  = DW'(am[DW-1:QF]) >= dm;
		prep.b_sat  = DW'(bm[DW-1:QF]) >= dm;
		prep.a.rem  = DW'(am[DW-1:QF]);
		prep.a.low  = {am[QF-1:0], {(QB-QF){1'b0}}};
		prep.a.quo  = '0;
		prep.b.rem  = DW'(bm[DW-1:QF]);
		prep.b.low  = {bm[QF-1:0], {(QB-QF){1'b0}}};
		prep.b.quo  = '0;
	end

	always_ff @(posedge clk) begin
		if (en) st_s[0] <= prep;
	end

	// Divider pipeline: one quotient bit per stage for both ratios
	for (genvar i = 0; i < QB; i++) begin : g_step
		stage_t nx;
		always_comb begin
			nx   = st_s[i];
			nx.a = div_step(st_s[i].a, st_s[i].d);
			nx.b = div_step(st_s[i].b, st_s[i].d);
		end
		always_ff @(posedge clk) begin
			if (en) st_s[i+1] <= nx;
		end
	end

	// Hold valid flags along the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= QB; i++) v_s[i] <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s[0] <= job_valid;
			for (int i = 1; i <= QB; i++) v_s[i] <= v_s[i-1];
			out_v_q <= v_s[QB];
		end
	end

	// Output word; zero weights unless a projection was solved
	always_ff @(posedge clk) begin
		if (en) begin
			out_q.status <= st_s[QB].status;
			if (st_s[QB].status == STATUS_XZ || st_s[QB].status == STATUS_XY ||
					st_s[QB].status == STATUS_YZ) begin
				out_q.alpha <= finish(st_s[QB].a.quo, st_s[QB].a_sat, st_s[QB].a_neg);
				out_q.beta  <= finish(st_s[QB].b.quo, st_s[QB].b_sat, st_s[QB].b_neg);
			end else begin
				out_q.alpha <= '0;
				out_q.beta  <= '0;
			end
		end
	end

endmodule

[rtl/triangle_affine_coordinates.sv]
`timescale 1ns / 1ps
// Channel   Direction  Word
// query     in         triangle vertices and query point, 12 x signed Q8.8
// result    out        alpha, beta (signed Q15.16, saturated), status
// wr_*      in         register writes: coplanar / determinant tolerance
//
// One word per cycle sustained while results are taken; a word passes 5 front stages,
// 1 queue slot, 33 divider stages and 1 output register. The divider retires one
// quotient bit per stage for both weights. Reset clears all valid flags and queue
// pointers and loads the tolerances with 1 and 0. A stalled result holds
// the back end only; the front keeps accepting until the queue fills.
module triangle_affine_coordinates #(
	parameter int FIFO_DEPTH = tac_pkg::FIFO_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [tac_pkg::CFG_INDEX_W-1:0]  wr_index,
	input  logic [tac_pkg::CFG_DATA_W-1:0]   wr_data,
	tac_stream_if.sink                       query,
	tac_stream_if.source                     result
);
	import tac_pkg::*;

	logic [CTOL_W-1:0] ctol_q;
	logic [DTOL_W-1:0] dtol_q;
	logic              push_valid, push_ready, pop_valid, pop_ready;
	tac_job_t          push_job, pop_job;
	fifo_status_t      fifo_stat;

	// Tolerance registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctol_q <= CTOL_W'(1);
			dtol_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_COPLANAR_TOL:    ctol_q <= wr_data[CTOL_W-1:0];
				REG_DETERMINANT_TOL: dtol_q <= wr_data[DTOL_W-1:0];
				default: ;
			endcase
		end
	end

	tac_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (query.valid),
		.in_ready   (query.ready),
		.item       (query.payload),
		.ctol       (ctol_q),
		.dtol       (dtol_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.job        (push_job)
	);

	tac_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_job),
		.stat       (fifo_stat)
	);

	tac_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (pop_valid),
		.job_ready (pop_ready),
		.job       (pop_job),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_word  (result.payload)
	);

	// Front stalls only behind a full queue
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!query.ready |-> fifo_stat.full)
		else $error("front stalled with room in queue");

	a_fifo_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(fifo_stat.full && fifo_stat.empty))
		else $error("queue both full and empty");

	// Unsolved classes carry zero weights
	a_zero_weights: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.payload.status == STATUS_NOT_COPLANAR ||
			result.payload.status == STATUS_DEGENERATE)
		|-> result.payload.alpha == '0 && result.payload.beta == '0)
		else $error("nonzero weights on unsolved word");

	a_ctol_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && wr_index == REG_COPLANAR_TOL |=> ctol_q == $past(wr_data[CTOL_W-1:0]))
		else $error("coplanar tolerance write lost");

endmodule

[test/triangle_affine_coordinates_test.sv]
`timescale 1ns / 1ps
module triangle_affine_coordinates_test;
	import tac_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] wr_index = '0;
	logic [CFG_DATA_W-1:0] wr_data = '0;

	tac_stream_if #(.payload_t(tac_in_t)) query ();
	tac_stream_if #(.payload_t(tac_out_t)) result ();

	triangle_affine_coordinates dut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data), .query(query.sink), .result(result.source)
	);

	always #1 clk = ~clk;

	// Predictor copy of the tolerances
	logic [CTOL_W-1:0] coplanar_tol;
	logic [DTOL_W-1:0] determinant_tol;

	tac_out_t expected_words[$];
	int errors = 0;
	bit quiet = 0;
	bit hold_result = 0;

	typedef struct {
		tac_in_t word;
		bit      known;
		tac_out_t value;
	} stim_row_t;

	// Truncated, saturated Q16 ratio
	function automatic logic [31:0] ratio_q16(input longint num, input longint den);
		logic [127:0] n, d, q;
		bit neg;
		n = num < 0 ? -num : num;
		d = den < 0 ? -den : den;
		neg = (num < 0) != (den < 0);
		q = (n << 16) / d;
		if (neg) begin
			if (q > 128'h8000_0000) q = 128'h8000_0000;
			return -q[31:0];
		end
		if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
		return q[31:0];
	endfunction

	function automatic tac_out_t affine_weights(input tac_in_t w);
		longint e[3][3];
		longint b[3], c[9];
		longint nx, ny, nz, det, an, bn;
		logic signed [127:0] trip;
		int u, v;
		tac_out_t r;
		b = '{w.base_x, w.base_y, w.base_z};
		c = '{w.first_x, w.first_y, w.first_z, w.second_x, w.second_y, w.second_z,
			w.query_x, w.query_y, w.query_z};
		for (int k = 0; k < 3; k++)
			for (int p = 0; p < 3; p++)
				e[k][p] = c[3*k+p] - b[p];
		nx = e[0][1]*e[1][2] - e[0][2]*e[1][1];
		ny = e[0][2]*e[1][0] - e[0][0]*e[1][2];
		nz = e[0][0]*e[1][1] - e[0][1]*e[1][0];
		trip = 128'(signed'(nx)) * e[2][0] + 128'(signed'(ny)) * e[2][1]
			+ 128'(signed'(nz)) * e[2][2];
		if (trip < 0) trip = -trip;
		r.alpha = '0;
		r.beta = '0;
		if (!(trip < {75'd0, coplanar_tol})) begin
			r.status = STATUS_NOT_COPLANAR;
			return r;
		end
		for (int p = 0; p < 3; p++) begin
			u = axis_u(p);
			v = axis_v(p);
			det = e[0][u]*e[1][v] - e[1][u]*e[0][v];
			if ((det < 0 ? -det : det) > longint'({29'd0, determinant_tol})) begin
				an = e[1][v]*e[2][u] - e[1][u]*e[2][v];
				bn = e[0][u]*e[2][v] - e[0][v]*e[2][u];
				r.alpha = ratio_q16(an, det);
				r.beta = ratio_q16(bn, det);
				r.status = status_t'(p);
				return r;
			end
		end
		r.status = STATUS_DEGENERATE;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_COPLANAR_TOL) coplanar_tol = val[CTOL_W-1:0];
		else if (idx == REG_DETERMINANT_TOL) determinant_tol = val[DTOL_W-1:0];
		@(posedge clk);
	endtask

	// Wait until every result is in, then let the pipeline drain
	task automatic drain();
		query.valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic send_word(input tac_in_t w, input bit known, input tac_out_t value);
		tac_out_t p;
		p = affine_weights(w);
		if (known && p != value) report_mismatch("table row status", p.status, value.status);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			query.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		expected_words.push_back(p);
		query.valid <= 1'b1;
		query.payload <= w;
		@(posedge clk);
		while (!query.ready) @(posedge clk);
	endtask

	function automatic tac_in_t random_word();
		tac_in_t w;
		logic [15:0] s;
		w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(0, 3))
			0: ;
			1: begin
				// Flat triangle in z with the query on it
				s = $urandom;
				w.base_z = s; w.first_z = s; w.second_z = s; w.query_z = s;
			end
			2: begin
				// Small coordinates, query as an exact vertex combination
				w.base_x = $urandom_range(0, 511) - 256;
				w.base_y = $urandom_range(0, 511) - 256;
				w.base_z = $urandom_range(0, 511) - 256;
				w.first_x = $urandom_range(0, 511) - 256;
				w.first_y = $urandom_range(0, 511) - 256;
				w.first_z = $urandom_range(0, 511) - 256;
				w.second_x = $urandom_range(0, 511) - 256;
				w.second_y = $urandom_range(0, 511) - 256;
				w.second_z = $urandom_range(0, 511) - 256;
				w.query_x = w.first_x + w.second_x - w.base_x;
				w.query_y = w.first_y + w.second_y - w.base_y;
				w.query_z = w.first_z + w.second_z - w.base_z;
			end
			default: begin
				// Collinear along x, query on the x axis line
				s = $urandom;
				w.base_y = s; w.first_y = s; w.second_y = s; w.query_y = s;
				w.first_z = w.base_z; w.second_z = w.base_z; w.query_z = w.base_z;
			end
		endcase
		return w;
	endfunction

	// Check each result word against the oldest expectation
	always @(posedge clk) begin
		if (result.valid && result.ready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word", 0, 0);
			end else begin
				tac_out_t w;
				w = expected_words.pop_front();
				if (result.payload.alpha !== w.alpha)
					report_mismatch("alpha", result.payload.alpha, w.alpha);
				if (result.payload.beta !== w.beta)
					report_mismatch("beta", result.payload.beta, w.beta);
				if (result.payload.status !== w.status)
					report_mismatch("status", result.payload.status, w.status);
			end
		end
	end

	// Result backpressure: random bursts, a long hold-off on request
	initial begin
		result.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_result) begin
				result.ready <= 1'b0;
				repeat (200) @(posedge clk);
				hold_result = 0;
				result.ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				result.ready <= 1'b0;
				repeat ($urandom_range(0, 4)) @(posedge clk);
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	initial begin
		#3000000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		stim_row_t rows[$];
		stim_row_t r;
		tac_out_t zero_out;
		query.valid = 1'b0;
		query.payload = '0;
		coplanar_tol = 1;
		determinant_tol = 0;
		zero_out = '{alpha: 0, beta: 0, status: STATUS_DEGENERATE};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		r.known = 1; r.word = '0; r.value = zero_out;
		rows.push_back(r);
		r.word = '{default: 16'sh7FFF}; rows.push_back(r);
		r.word = '{default: -16'sh8000}; rows.push_back(r);
		r.known = 0;
		r.word = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000,
			16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
		rows.push_back(r);
		r.word = '{0, 0, 0, 256, 0, 0, 0, 0, 256, 128, 0, 64}; rows.push_back(r);
		r.word = '{0, 0, 0, 256, 0, 0, 0, 256, 0, 128, 64, 0}; rows.push_back(r);
		r.word = '{0, 0, 0, 0, 256, 0, 0, 0, 256, 0, 64, 128}; rows.push_back(r);
		r.word = '{0, 0, 0, 1, 0, 0, 0, 0, 1, 16'sh7FFF, 0, 16'sh8000}; rows.push_back(r);
		r.word = '{0, 0, 0, 1, 0, 0, 0, 0, 1, 16'sh8000, 0, 16'sh7FFF}; rows.push_back(r);
		r.word = '{0, 0, 0, 3, 0, 0, 0, 0, 3, 1, 0, -1}; rows.push_back(r);
		r.known = 1; r.value = '{alpha: 0, beta: 0, status: STATUS_NOT_COPLANAR};
		r.word = '{0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 256}; rows.push_back(r);
		r.known = 0;
		r.word = '{10, 20, 30, 10, 20, 30, 100, 200, 300, 55, 110, 165}; rows.push_back(r);
		foreach (rows[i]) send_word(rows[i].word, rows[i].known, rows[i].value);
		drain();

		// Register settings, extremes included, then random words each
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin write_reg(REG_COPLANAR_TOL, 1); write_reg(REG_DETERMINANT_TOL, 0); end
				1: begin
					write_reg(REG_COPLANAR_TOL, {CFG_DATA_W{1'b1}});
					write_reg(REG_DETERMINANT_TOL, {CFG_DATA_W{1'b1}});
				end
				2: begin
					write_reg(REG_COPLANAR_TOL, 53'h1F_FFFF_FFFF_FFFF);
					write_reg(REG_DETERMINANT_TOL, $urandom_range(0, 70000));
					write_reg(2'd3, $urandom);
				end
				3: begin write_reg(REG_COPLANAR_TOL, 0); write_reg(REG_DETERMINANT_TOL, 5); end
				default: begin
					write_reg(REG_COPLANAR_TOL, CFG_DATA_W'({$urandom, $urandom}));
					write_reg(REG_DETERMINANT_TOL, CFG_DATA_W'({$urandom, $urandom}));
				end
			endcase
			// Hold off results long enough to fill the whole pipeline and stall the input
			if (ph == 1) begin
				hold_result = 1;
				for (int i = 0; i < 60; i++) send_word(random_word(), 0, zero_out);
			end
			if (ph == 4) quiet = 1;
			for (int i = 0; i < 115; i++) send_word(random_word(), 0, zero_out);
			drain();
		end

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
